### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the decoder top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/atkd_pkg.sv
// ----------------------------------------------------------------------------
// atkd_pkg
// Constants, key codes and decode helpers for the terminal key decoder.
// ----------------------------------------------------------------------------
package atkd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE = '0;

   localparam logic [1:0] MODE_BYTE   = 2'd0;
   localparam logic [1:0] MODE_POLL   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [7:0] ASCII_BS       = 8'd8;
   localparam logic [7:0] ASCII_TAB      = 8'd9;
   localparam logic [7:0] ASCII_LF       = 8'd10;
   localparam logic [7:0] ASCII_CR       = 8'd13;
   localparam logic [7:0] ASCII_ESC      = 8'd27;
   localparam logic [7:0] ASCII_SPACE    = 8'd32;
   localparam logic [7:0] ASCII_TILDE    = 8'd126;
   localparam logic [7:0] ASCII_DEL      = 8'd127;
   localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
   localparam logic [7:0] ASCII_UPPER_O  = 8'h4F;
   localparam logic [7:0] ASCII_UPPER_A  = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z  = 8'h5A;
   localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

   localparam logic [4:0] K_NONE   = 5'd0;
   localparam logic [4:0] K_ESC    = 5'd1;
   localparam logic [4:0] K_RETURN = 5'd2;
   localparam logic [4:0] K_TAB    = 5'd3;
   localparam logic [4:0] K_BKSP   = 5'd4;
   localparam logic [4:0] K_SPACE  = 5'd5;
   localparam logic [4:0] K_UP     = 5'd6;
   localparam logic [4:0] K_DOWN   = 5'd7;
   localparam logic [4:0] K_LEFT   = 5'd8;
   localparam logic [4:0] K_RIGHT  = 5'd9;
   localparam logic [4:0] K_HOME   = 5'd10;
   localparam logic [4:0] K_END    = 5'd11;
   localparam logic [4:0] K_INS    = 5'd12;
   localparam logic [4:0] K_DEL    = 5'd13;
   localparam logic [4:0] K_PGUP   = 5'd14;
   localparam logic [4:0] K_PGDN   = 5'd15;
   localparam logic [4:0] K_CHAR   = 5'd16;

   typedef struct packed {
      logic [4:0] code;
      logic [7:0] char_val;
   } key_type;

   // Ring pointer plus offset, wrapped at the queue depth. The offset is
   // never larger than the depth, so one subtraction covers the wrap.
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, ofs};
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // Key for a single byte that is not ESC. Unlisted control bytes give none.
   function automatic key_type classify_byte(input logic [7:0] v);
      key_type k;
      k.code     = K_NONE;
      k.char_val = 8'd0;
      if (v == ASCII_CR || v == ASCII_LF) begin
         k.code = K_RETURN;
      end else if (v == ASCII_TAB) begin
         k.code = K_TAB;
      end else if (v == ASCII_BS || v == ASCII_DEL) begin
         k.code = K_BKSP;
      end else if (v == ASCII_SPACE) begin
         k.code = K_SPACE;
      end else if (v > ASCII_SPACE && v <= ASCII_TILDE) begin
         k.code = K_CHAR;
         if (v >= ASCII_UPPER_A && v <= ASCII_UPPER_Z) begin
            k.char_val = v + ASCII_CASE_OFS;
         end else begin
            k.char_val = v;
         end
      end
      return k;
   endfunction

   // Final letter of ESC [ x or ESC O x.
   function automatic logic [4:0] letter_key(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h41:   k = K_UP;
         8'h42:   k = K_DOWN;
         8'h43:   k = K_RIGHT;
         8'h44:   k = K_LEFT;
         8'h48:   k = K_HOME;
         8'h46:   k = K_END;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   // Digit of ESC [ d ~.
   function automatic logic [4:0] tilde_key(input logic [7:0] c);
      logic [4:0] k;
      case (c) inside
         8'h31, 8'h37: k = K_HOME;
         8'h32:        k = K_INS;
         8'h33:        k = K_DEL;
         8'h34, 8'h38: k = K_END;
         8'h35:        k = K_PGUP;
         8'h36:        k = K_PGDN;
         default:      k = K_NONE;
      endcase
      return k;
   endfunction

endpackage

### design/ansi_terminal_key_decoder_top.sv
// ----------------------------------------------------------------------------
// ansi_terminal_key_decoder_top
// Queues terminal bytes in a ring memory and decodes them into key codes.
// ----------------------------------------------------------------------------
// A byte arrival, a clear and an unused mode return their item in the
// next cycle. A poll reads the ring memory one byte per cycle through its
// single read port: it reads the head byte first, then looks at one byte
// per step, up to the bytes of an escape sequence, and skips any control
// bytes before a key, at most the whole ring. No reset sweep is needed;
// only ring data inside its occupied part is used. A new item is taken
// once no poll is running and the previous result has been taken or is
// taken in the same cycle.
`include "assert_macros.svh"

module ansi_terminal_key_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [4:0]                           rsp_key_code,
   output logic [7:0]                           rsp_key_char,
   output logic                                 rsp_byte_dropped,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [atkd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [atkd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [atkd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EVAL = 1'b1;

   logic [7:0] ring_mem [atkd_pkg::QUEUE_DEPTH];

   logic                             state_ff, state_in;
   logic [1:0]                       off_ff, off_in;
   logic [atkd_pkg::PTR_W-1:0]       head_ff, head_in;
   logic [atkd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             held_ff, held_in;
   logic                             enable_ff, enable_in;
   logic [7:0]                       b1_ff, b1_in;
   logic [7:0]                       b2_ff, b2_in;
   logic [7:0]                       rd_data_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [4:0]                       rsp_code_ff, rsp_code_in;
   logic [7:0]                       rsp_char_ff, rsp_char_in;
   logic                             rsp_drop_ff, rsp_drop_in;

   logic                             req_fire;
   logic                             csr_wr;
   logic                             mem_we;
   logic [atkd_pkg::PTR_W-1:0]       wr_addr;
   logic [atkd_pkg::PTR_W-1:0]       rd_addr;
   logic [atkd_pkg::CNT_W-1:0]       drop_n;
   logic                             do_drop;
   logic [4:0]                       seq_key;
   atkd_pkg::key_type                cls;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = psel && penable && pwrite && (paddr == atkd_pkg::REG_ENABLE);

   assign wr_addr = atkd_pkg::ptr_add(head_ff, cnt_ff);
   assign rd_addr = (state_ff == S_IDLE) ? head_ff :
                    atkd_pkg::ptr_add(head_ff, atkd_pkg::CNT_W'(off_ff) + 1'b1);

   assign cls = atkd_pkg::classify_byte(rd_data_ff);

   // A finished escape sequence: a letter at the third byte, or a digit
   // followed by a tilde at the fourth.
   always_comb begin
      seq_key = atkd_pkg::K_NONE;
      if (off_ff == 2'd2) begin
         seq_key = atkd_pkg::letter_key(rd_data_ff);
      end else if (off_ff == 2'd3 && rd_data_ff == atkd_pkg::ASCII_TILDE) begin
         seq_key = atkd_pkg::tilde_key(b2_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      held_in      = held_ff;
      enable_in    = enable_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_drop_in  = rsp_drop_ff;
      mem_we       = 1'b0;
      drop_n       = '0;
      do_drop      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = atkd_pkg::K_NONE;
               rsp_char_in  = 8'd0;
               rsp_drop_in  = 1'b0;
               unique case (req_mode)
                  atkd_pkg::MODE_BYTE: begin
                     if (cnt_ff < atkd_pkg::CNT_W'(atkd_pkg::QUEUE_DEPTH)) begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        rsp_drop_in = 1'b1;
                     end
                  end
                  atkd_pkg::MODE_POLL: begin
                     if (enable_ff && cnt_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_EVAL;
                        off_in       = 2'd0;
                     end
                  end
                  atkd_pkg::MODE_CLEAR: begin
                     head_in = '0;
                     cnt_in  = '0;
                     held_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (off_ff == 2'd0 && rd_data_ff != atkd_pkg::ASCII_ESC) begin
               // Plain byte: consume it, report it or skip to the next one.
               held_in = 1'b0;
               do_drop = 1'b1;
               drop_n  = atkd_pkg::CNT_W'(1);
               if (cls.code != atkd_pkg::K_NONE || cnt_ff == atkd_pkg::CNT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = cls.code;
                  rsp_char_in  = cls.char_val;
                  state_in     = S_IDLE;
               end
            end else if (off_ff == 2'd0 && cnt_ff >= atkd_pkg::CNT_W'(2)) begin
               off_in = 2'd1;
            end else if (off_ff == 2'd1 && cnt_ff >= atkd_pkg::CNT_W'(3) &&
                         (rd_data_ff == atkd_pkg::ASCII_LBRACKET ||
                          rd_data_ff == atkd_pkg::ASCII_UPPER_O)) begin
               b1_in  = rd_data_ff;
               off_in = 2'd2;
            end else if (off_ff == 2'd2 && b1_ff == atkd_pkg::ASCII_LBRACKET &&
                         cnt_ff >= atkd_pkg::CNT_W'(4) &&
                         atkd_pkg::tilde_key(rd_data_ff) != atkd_pkg::K_NONE) begin
               b2_in  = rd_data_ff;
               off_in = 2'd3;
            end else begin
               // The escape decision: a full sequence, a hold, or a bare ESC.
               rsp_valid_in = 1'b1;
               rsp_char_in  = 8'd0;
               state_in     = S_IDLE;
               if (seq_key != atkd_pkg::K_NONE) begin
                  held_in     = 1'b0;
                  rsp_code_in = seq_key;
                  do_drop     = 1'b1;
                  drop_n      = (off_ff == 2'd2) ? atkd_pkg::CNT_W'(3) : atkd_pkg::CNT_W'(4);
               end else if (!held_ff &&
                            (cnt_ff == atkd_pkg::CNT_W'(1) ||
                             (cnt_ff == atkd_pkg::CNT_W'(2) && off_ff == 2'd1 &&
                              (rd_data_ff == atkd_pkg::ASCII_LBRACKET ||
                               rd_data_ff == atkd_pkg::ASCII_UPPER_O)))) begin
                  held_in     = 1'b1;
                  rsp_code_in = atkd_pkg::K_NONE;
               end else begin
                  held_in     = 1'b0;
                  rsp_code_in = atkd_pkg::K_ESC;
                  do_drop     = 1'b1;
                  drop_n      = atkd_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_drop) begin
         if (drop_n >= cnt_ff) begin
            head_in = '0;
            cnt_in  = '0;
         end else begin
            head_in = atkd_pkg::ptr_add(head_ff, drop_n);
            cnt_in  = cnt_ff - drop_n;
         end
      end

      if (csr_wr) begin
         if (!pwdata[0] || !enable_ff) begin
            head_in = '0;
            cnt_in  = '0;
            held_in = 1'b0;
         end
         enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_addr] <= req_rx_byte;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         off_ff       <= 2'd0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         held_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         off_ff       <= off_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         held_ff      <= held_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      rsp_code_ff <= rsp_code_in;
      rsp_char_ff <= rsp_char_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = rsp_code_ff;
   assign rsp_key_char     = rsp_char_ff;
   assign rsp_byte_dropped = rsp_drop_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == atkd_pkg::REG_ENABLE) ?
                   {{(atkd_pkg::CSR_DATA_W - 1){1'b0}}, enable_ff} : '0;

   `ASSERT_IMPLY(a_cnt_range, clock, reset, 1'b1,
                 cnt_ff <= atkd_pkg::CNT_W'(atkd_pkg::QUEUE_DEPTH))
   `ASSERT_IMPLY(a_eval_out_free, clock, reset, state_ff == S_EVAL, !rsp_valid_ff)
   `ASSERT_IMPLY(a_held_nonempty, clock, reset, held_ff, cnt_ff != '0)
   `ASSERT_NEXT(a_push_count, clock, reset,
                req_fire && req_mode == atkd_pkg::MODE_BYTE && !csr_wr &&
                cnt_ff < atkd_pkg::CNT_W'(atkd_pkg::QUEUE_DEPTH),
                cnt_ff == $past(cnt_ff) + 1'b1)

endmodule
